// ===== hw/rtl/mwe_pkg.sv =====
// Shared types and constants for the Microwire serial EEPROM master.
// Used by mwe_seq and microwire_eeprom_master_unit; no dependencies.
package mwe_pkg;

    // Memory geometry
    localparam int ADDR_BITS  = 9;
    localparam int DATA_BITS  = 8;
    localparam int CMD_BITS   = ADDR_BITS + 3;
    localparam int END_CLOCKS = 5;

    // Counter and index widths
    localparam int CNT_W     = $clog2(CMD_BITS > DATA_BITS ? CMD_BITS : DATA_BITS);
    localparam int CMD_IDX_W = $clog2(CMD_BITS);
    localparam int DAT_IDX_W = $clog2(DATA_BITS);

    // Port field widths
    localparam int OP_W     = 2;
    localparam int ADDR_W   = 9;
    localparam int BYTE_W   = 8;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 4;

    // Operation codes
    localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
    localparam logic [OP_W-1:0] OP_READ  = 2'd1;
    localparam logic [OP_W-1:0] OP_WRITE = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_HALF_PERIOD = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POLL_LIMIT  = 4'd1;

    localparam logic [CFG_W-1:0] HALF_PERIOD_RST = 16'd50;
    localparam logic [CFG_W-1:0] POLL_LIMIT_RST  = 16'd0;

    // Command frames: start bit, 2-bit opcode, address bits
    localparam logic [CMD_BITS-1:0] START_BIT = CMD_BITS'(1) << (ADDR_BITS + 2);
    localparam logic [CMD_BITS-1:0] CMD_WDS = START_BIT | (CMD_BITS'(4'h0) << (ADDR_BITS - 2));
    localparam logic [CMD_BITS-1:0] CMD_WEN = START_BIT | (CMD_BITS'(4'h3) << (ADDR_BITS - 2));
    localparam logic [CMD_BITS-1:0] CMD_WR  = START_BIT | (CMD_BITS'(4'h4) << (ADDR_BITS - 2));
    localparam logic [CMD_BITS-1:0] CMD_RD  = START_BIT | (CMD_BITS'(4'h8) << (ADDR_BITS - 2));

    // Sequencer steps
    localparam int STEP_W = 5;
    localparam logic [STEP_W-1:0] S_IDLE  = 5'd0;
    localparam logic [STEP_W-1:0] S_C_SK0 = 5'd1;
    localparam logic [STEP_W-1:0] S_C_DI0 = 5'd2;
    localparam logic [STEP_W-1:0] S_C_CS1 = 5'd3;
    localparam logic [STEP_W-1:0] S_C_DH  = 5'd4;
    localparam logic [STEP_W-1:0] S_C_DL  = 5'd5;
    localparam logic [STEP_W-1:0] S_C_BIT = 5'd6;
    localparam logic [STEP_W-1:0] S_C_BH  = 5'd7;
    localparam logic [STEP_W-1:0] S_C_BL  = 5'd8;
    localparam logic [STEP_W-1:0] S_C_END = 5'd9;
    localparam logic [STEP_W-1:0] S_R_H   = 5'd10;
    localparam logic [STEP_W-1:0] S_R_L   = 5'd11;
    localparam logic [STEP_W-1:0] S_R_S   = 5'd12;
    localparam logic [STEP_W-1:0] S_W_BIT = 5'd13;
    localparam logic [STEP_W-1:0] S_W_H   = 5'd14;
    localparam logic [STEP_W-1:0] S_W_L   = 5'd15;
    localparam logic [STEP_W-1:0] S_E_DI0 = 5'd16;
    localparam logic [STEP_W-1:0] S_E_CS0 = 5'd17;
    localparam logic [STEP_W-1:0] S_E_H   = 5'd18;
    localparam logic [STEP_W-1:0] S_E_L   = 5'd19;
    localparam logic [STEP_W-1:0] S_P_CS1 = 5'd20;
    localparam logic [STEP_W-1:0] S_P_DH  = 5'd21;
    localparam logic [STEP_W-1:0] S_P_DL  = 5'd22;
    localparam logic [STEP_W-1:0] S_P_H   = 5'd23;
    localparam logic [STEP_W-1:0] S_P_L   = 5'd24;
    localparam logic [STEP_W-1:0] S_P_S   = 5'd25;

    // Phases of a request
    localparam int STAGE_W = 3;
    localparam logic [STAGE_W-1:0] G_READ    = 3'd0;
    localparam logic [STAGE_W-1:0] G_ENABLE  = 3'd1;
    localparam logic [STAGE_W-1:0] G_WRITE   = 3'd2;
    localparam logic [STAGE_W-1:0] G_POLL    = 3'd3;
    localparam logic [STAGE_W-1:0] G_DISABLE = 3'd4;

    // One result item
    typedef struct packed {
        logic              chip_select;
        logic              serial_clock;
        logic              data_to_chip;
        logic              busy;
        logic              done;
        logic [BYTE_W-1:0] read_data;
        logic              timeout;
    } mwe_res_t;

endpackage

// ===== hw/rtl/microwire_eeprom_master_unit.sv =====
// Top level of the Microwire serial EEPROM master: handshakes, config, result register.
// Depends on mwe_pkg and mwe_seq.
//
// Usage:
//   Each transfer on the s_ channel is one tick of the serial interface. It may
//   start a read (s_operation = 1) or a write (s_operation = 2) at s_address;
//   requests arriving while a sequence runs are ignored. s_data_from_chip is
//   the memory's data-out level sampled on that tick.
//   Each tick yields exactly one transfer on the m_ channel: pin levels for
//   chip select, shift clock and data-in, plus busy, done, last read byte and
//   a timeout flag raised with done when the busy poll hit its limit.
//   Pins change once every half_period_ticks ticks (register 0); register 1
//   bounds the busy poll after a write, zero meaning no bound. The cfg_ port
//   is always ready and should be written only while no sequence is running.
// Timing:
//   An s_ transfer is held in the input register, and the sequencer then steps
//   it into the result register, which drives m_valid.
//   Throughput is one tick per cycle while m_ready keeps the result slot free.
// Reset and stalls:
//   aresetn (synchronous, active low) returns the sequencer to idle with all
//   pins low and the registers to half period 50, poll limit 0. When m_ready
//   is low the result holds, the input register fills and then s_ready drops.
module microwire_eeprom_master_unit (
    input  logic                           aclk,
    input  logic                           aresetn,
    // input ticks
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [mwe_pkg::OP_W-1:0]       s_operation,
    input  logic [mwe_pkg::ADDR_W-1:0]     s_address,
    input  logic [mwe_pkg::BYTE_W-1:0]     s_write_data,
    input  logic                           s_data_from_chip,
    // results
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_chip_select,
    output logic                           m_serial_clock,
    output logic                           m_data_to_chip,
    output logic                           m_busy_res,
    output logic                           m_done_res,
    output logic [mwe_pkg::BYTE_W-1:0]     m_read_data,
    output logic                           m_timeout,
    // configuration writes
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [mwe_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mwe_pkg::CFG_W-1:0]      cfg_data
);
    import mwe_pkg::*;

    logic                 in_valid_reg;
    logic [OP_W-1:0]      op_reg;
    logic [ADDR_W-1:0]    addr_reg;
    logic [BYTE_W-1:0]    wdata_reg;
    logic                 din_reg;
    logic                 out_valid_reg;
    mwe_res_t             res_reg;
    mwe_res_t             res_next;
    logic [CFG_W-1:0]     half_period_reg;
    logic [CFG_W-1:0]     poll_limit_reg;
    logic                 advance;

    // step the sequencer when a tick is held and the result slot frees up
    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            op_reg    <= s_operation;
            addr_reg  <= s_address;
            wdata_reg <= s_write_data;
            din_reg   <= s_data_from_chip;
        end
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            half_period_reg <= HALF_PERIOD_RST;
            poll_limit_reg  <= POLL_LIMIT_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_HALF_PERIOD: half_period_reg <= cfg_data;
                REG_POLL_LIMIT:  poll_limit_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    mwe_seq u_seq (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .step_en        (advance),
        .operation      (op_reg),
        .address        (addr_reg),
        .write_data     (wdata_reg),
        .data_from_chip (din_reg),
        .half_period    (half_period_reg),
        .poll_limit     (poll_limit_reg),
        .res_next       (res_next)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            res_reg <= res_next;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_chip_select  = res_reg.chip_select;
    assign m_serial_clock = res_reg.serial_clock;
    assign m_data_to_chip = res_reg.data_to_chip;
    assign m_busy_res     = res_reg.busy;
    assign m_done_res     = res_reg.done;
    assign m_read_data    = res_reg.read_data;
    assign m_timeout      = res_reg.timeout;

    // timeout only accompanies the finishing tick
    a_timeout_done: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && res_reg.timeout |-> res_reg.done)
        else $error("timeout without done");

    // a finishing tick reports the block idle
    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && res_reg.done |-> !res_reg.busy)
        else $error("done while still busy");

    // the result slot only empties through a transfer
    a_out_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !m_ready && !advance |=> out_valid_reg)
        else $error("result dropped without transfer");

endmodule

// ===== hw/rtl/mwe_seq.sv =====
// Microwire pin sequencer: holds the frame state and computes one tick per step.
// Depends on mwe_pkg.
module mwe_seq (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          step_en,
    input  logic [mwe_pkg::OP_W-1:0]      operation,
    input  logic [mwe_pkg::ADDR_W-1:0]    address,
    input  logic [mwe_pkg::BYTE_W-1:0]    write_data,
    input  logic                          data_from_chip,
    input  logic [mwe_pkg::CFG_W-1:0]     half_period,
    input  logic [mwe_pkg::CFG_W-1:0]     poll_limit,
    output mwe_pkg::mwe_res_t             res_next
);
    import mwe_pkg::*;

    logic [STEP_W-1:0]    step_reg, step_next;
    logic [STAGE_W-1:0]   stage_reg, stage_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [CMD_BITS-1:0]  cmd_reg, cmd_next;
    logic [DATA_BITS-1:0] data_reg, data_next;
    logic [DATA_BITS-1:0] rval_reg, rval_next;
    logic [ADDR_BITS-1:0] addr_reg, addr_next;
    logic [CFG_W-1:0]     wait_reg, wait_next;
    logic [CFG_W-1:0]     poll_reg, poll_next;
    logic                 cs_reg, cs_next;
    logic                 sk_reg, sk_next;
    logic                 di_reg, di_next;
    logic                 tflag_reg, tflag_next;

    logic [CFG_W-1:0]     period;
    logic [CFG_W-1:0]     poll_inc;
    logic                 finished;
    logic                 done;
    logic                 tout;

    // zero half period runs as one tick
    assign period   = (half_period == '0) ? CFG_W'(1) : half_period;
    assign poll_inc = (poll_reg == '1) ? poll_reg : poll_reg + CFG_W'(1);

    // next state for one tick
    always_comb begin
        step_next  = step_reg;
        stage_next = stage_reg;
        cnt_next   = cnt_reg;
        cmd_next   = cmd_reg;
        data_next  = data_reg;
        rval_next  = rval_reg;
        addr_next  = addr_reg;
        wait_next  = wait_reg;
        poll_next  = poll_reg;
        cs_next    = cs_reg;
        sk_next    = sk_reg;
        di_next    = di_reg;
        tflag_next = tflag_reg;
        finished   = 1'b0;
        done       = 1'b0;
        tout       = 1'b0;

        if (step_reg == S_IDLE) begin
            if (operation == OP_READ || operation == OP_WRITE) begin
                addr_next  = ADDR_BITS'(address);
                wait_next  = period;
                tflag_next = 1'b0;
                step_next  = S_C_SK0;
                if (operation == OP_READ) begin
                    stage_next = G_READ;
                    cmd_next   = CMD_RD | CMD_BITS'(ADDR_BITS'(address));
                end else begin
                    stage_next = G_ENABLE;
                    data_next  = DATA_BITS'(write_data);
                    cmd_next   = CMD_WEN;
                end
            end
        end else if (wait_reg > CFG_W'(1)) begin
            wait_next = wait_reg - CFG_W'(1);
        end else begin
            // pin event due
            unique case (step_reg)
                S_C_SK0: begin sk_next = 1'b0; step_next = S_C_DI0; end
                S_C_DI0: begin di_next = 1'b0; step_next = S_C_CS1; end
                S_C_CS1: begin cs_next = 1'b1; step_next = S_C_DH; end
                S_C_DH:  begin sk_next = 1'b1; step_next = S_C_DL; end
                S_C_DL: begin
                    sk_next   = 1'b0;
                    cnt_next  = CNT_W'(CMD_BITS - 1);
                    step_next = S_C_BIT;
                end
                S_C_BIT: begin
                    di_next   = cmd_reg[cnt_reg[CMD_IDX_W-1:0]];
                    step_next = S_C_BH;
                end
                S_C_BH: begin sk_next = 1'b1; step_next = S_C_BL; end
                S_C_BL: begin
                    sk_next = 1'b0;
                    if (cnt_reg == '0) begin
                        step_next = S_C_END;
                    end else begin
                        cnt_next  = cnt_reg - CNT_W'(1);
                        step_next = S_C_BIT;
                    end
                end
                S_C_END: begin
                    di_next = 1'b0;
                    if (stage_reg == G_READ) begin
                        cnt_next  = CNT_W'(DATA_BITS - 1);
                        data_next = '0;
                        step_next = S_R_H;
                    end else if (stage_reg == G_WRITE) begin
                        cnt_next  = CNT_W'(DATA_BITS - 1);
                        step_next = S_W_BIT;
                    end else begin
                        step_next = S_E_DI0;
                    end
                end
                S_R_H: begin sk_next = 1'b1; step_next = S_R_L; end
                S_R_L: begin sk_next = 1'b0; step_next = S_R_S; end
                S_R_S: begin
                    data_next = {data_reg[DATA_BITS-2:0], data_from_chip};
                    if (cnt_reg == '0) begin
                        step_next = S_E_DI0;
                    end else begin
                        cnt_next  = cnt_reg - CNT_W'(1);
                        step_next = S_R_H;
                    end
                end
                S_W_BIT: begin
                    di_next   = data_reg[cnt_reg[DAT_IDX_W-1:0]];
                    step_next = S_W_H;
                end
                S_W_H: begin sk_next = 1'b1; step_next = S_W_L; end
                S_W_L: begin
                    sk_next = 1'b0;
                    if (cnt_reg == '0) begin
                        step_next = S_E_DI0;
                    end else begin
                        cnt_next  = cnt_reg - CNT_W'(1);
                        step_next = S_W_BIT;
                    end
                end
                S_E_DI0: begin di_next = 1'b0; step_next = S_E_CS0; end
                S_E_CS0: begin
                    cs_next   = 1'b0;
                    cnt_next  = CNT_W'(END_CLOCKS - 1);
                    step_next = S_E_H;
                end
                S_E_H: begin sk_next = 1'b1; step_next = S_E_L; end
                S_E_L: begin
                    sk_next = 1'b0;
                    if (cnt_reg != '0) begin
                        cnt_next  = cnt_reg - CNT_W'(1);
                        step_next = S_E_H;
                    end else if (stage_reg == G_READ) begin
                        rval_next = data_reg;
                        step_next = S_IDLE;
                        finished  = 1'b1;
                    end else if (stage_reg == G_ENABLE) begin
                        stage_next = G_WRITE;
                        cmd_next   = CMD_WR | CMD_BITS'(addr_reg);
                        step_next  = S_C_SK0;
                    end else if (stage_reg == G_WRITE) begin
                        stage_next = G_POLL;
                        poll_next  = '0;
                        step_next  = S_P_CS1;
                    end else if (stage_reg == G_POLL) begin
                        stage_next = G_DISABLE;
                        cmd_next   = CMD_WDS;
                        step_next  = S_C_SK0;
                    end else begin
                        step_next = S_IDLE;
                        finished  = 1'b1;
                    end
                end
                S_P_CS1: begin cs_next = 1'b1; step_next = S_P_DH; end
                S_P_DH:  begin sk_next = 1'b1; step_next = S_P_DL; end
                S_P_DL:  begin sk_next = 1'b0; step_next = S_P_H; end
                S_P_H:   begin sk_next = 1'b1; step_next = S_P_L; end
                S_P_L:   begin sk_next = 1'b0; step_next = S_P_S; end
                S_P_S: begin
                    // busy poll: chip raises data-out when the write is done
                    if (data_from_chip) begin
                        step_next = S_E_DI0;
                    end else begin
                        poll_next = poll_inc;
                        if (poll_limit != '0 && poll_inc >= poll_limit) begin
                            tflag_next = 1'b1;
                            step_next  = S_E_DI0;
                        end else begin
                            step_next = S_P_H;
                        end
                    end
                end
                default: begin
                    step_next = S_IDLE;
                    finished  = 1'b1;
                end
            endcase

            if (finished) begin
                done       = 1'b1;
                tout       = tflag_next;
                tflag_next = 1'b0;
                wait_next  = '0;
            end else begin
                wait_next = period;
            end
        end
    end

    // result seen after this tick
    always_comb begin
        res_next.chip_select  = cs_next;
        res_next.serial_clock = sk_next;
        res_next.data_to_chip = di_next;
        res_next.busy         = (step_next != S_IDLE);
        res_next.done         = done;
        res_next.read_data    = rval_next[BYTE_W-1:0];
        res_next.timeout      = tout;
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg  <= S_IDLE;
            stage_reg <= G_READ;
            cnt_reg   <= '0;
            rval_reg  <= '0;
            wait_reg  <= '0;
            poll_reg  <= '0;
            cs_reg    <= 1'b0;
            sk_reg    <= 1'b0;
            di_reg    <= 1'b0;
            tflag_reg <= 1'b0;
        end else if (step_en) begin
            step_reg  <= step_next;
            stage_reg <= stage_next;
            cnt_reg   <= cnt_next;
            rval_reg  <= rval_next;
            wait_reg  <= wait_next;
            poll_reg  <= poll_next;
            cs_reg    <= cs_next;
            sk_reg    <= sk_next;
            di_reg    <= di_next;
            tflag_reg <= tflag_next;
        end
    end

    // frame payload
    always_ff @(posedge aclk) begin
        if (step_en) begin
            cmd_reg  <= cmd_next;
            data_reg <= data_next;
            addr_reg <= addr_next;
        end
    end

    // an active sequence always has an event wait pending
    a_wait_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        step_reg != S_IDLE |-> wait_reg != '0)
        else $error("wait counter empty during a sequence");

    // chip select only rises at the frame-opening steps
    a_cs_rise: assert property (@(posedge aclk) disable iff (!aresetn)
        step_en && !cs_reg && cs_next |-> (step_reg == S_C_CS1 || step_reg == S_P_CS1))
        else $error("chip select raised outside frame start");

    // a finished sequence has released chip select and the clock
    a_done_pins: assert property (@(posedge aclk) disable iff (!aresetn)
        step_en && done |-> !cs_next && !sk_next)
        else $error("sequence finished with pins active");

endmodule
